[hdl/ppd_pkg.sv]
// Shared types and constants of the point to polyline distance block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 8;
  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int MUL_W        = DIFF_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DD_W         = 2 * DIFF_W;
  localparam int DOT_W        = DD_W + 1;
  localparam int MAG_W        = 2 * COORD_W + 1;
  localparam int MAG_LO_W     = DIFF_W;
  localparam int MAG_HI_W     = MAG_W - MAG_LO_W;
  localparam int NUM_W        = 2 * MAG_W;
  localparam int CAND_W       = 2 * COORD_W + 1;
  localparam int ROOT_W       = 25;
  localparam int REM_W        = ROOT_W + 2;
  localparam int DIV_CNT_W    = $clog2(CAND_W);
  localparam int SQ_CNT_W     = $clog2(ROOT_W);
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 32;

  localparam logic [CNT_W-1:0] VCOUNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] VCOUNT_MAX   = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(2);

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RDA  = 8'b0000_0010,
    ST_RDB  = 8'b0000_0100,
    ST_DIFF = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  typedef enum logic [3:0] {
    MS_DXDX, MS_DYDY, MS_VXDX, MS_VYDY, MS_VXVX, MS_VYVY, MS_WXWX, MS_WYWY,
    MS_VXDY, MS_VYDX, MS_GAP, MS_HH, MS_HL, MS_LL, MS_TAIL, MS_DECIDE
  } mul_step_e;

endpackage

`default_nettype wire

[hdl/ppd_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
// Depends on ppd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ppd_sqrt import ppd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CAND_W-1:0] radicand_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic [2*ROOT_W-1:0] rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic                run_q;
  logic                done_q;

  logic [REM_W+1:0] rem_s;
  logic [REM_W+1:0] trial;
  logic             fit;

  assign rem_s = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
  assign trial = (REM_W+2)'({root_q, 2'b01});
  assign fit   = rem_s >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + SQ_CNT_W'(1);
        if (cnt_q == SQ_CNT_W'(ROOT_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= (2*ROOT_W)'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q <= {rad_q[2*ROOT_W-3:0], 2'b00};
      if (fit) begin
        rem_q  <= REM_W'(rem_s - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= REM_W'(rem_s);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[hdl/point_to_polyline_distance_top.sv]
// Top level: vertex memories, segment sequencer, shared multiplier, divider.
// Depends on ppd_pkg and ppd_sqrt.
//
//  channel   | direction | handshake             | payload
//  s_axis    | in        | tvalid/tready         | tuser=kind, tdata=index,x,y
//  m_axis    | out       | tvalid/tready         | tuser=status, tdata=distance
//  cfg       | in        | cfg_we_i              | cfg_wdata_i = vertex_count
//
// A load item's result is registered and appears in the cycle after it is accepted.
// A query's time grows with the vertex count n and is set by the 16-step multiply
// sequence per segment and the one-bit-per-cycle divider, run where a segment needs it.
// Reset clears control state only; vertex memories hold garbage until loaded.
// The input stalls while a query runs or while a result waits and cannot move.
`timescale 1ns / 1ps
`default_nettype none

module point_to_polyline_distance_top import ppd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // vertex_index, point_x, point_y
  input  wire logic                  s_axis_tuser,  // kind
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // distance, zero fill
  output logic                       m_axis_tuser,  // status
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i
);

  logic [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic [COORD_W-1:0] rdx_q, rdy_q;
  logic [ADDR_W-1:0]  rd_addr;

  state_e             state_q, state_d;
  mul_step_e          mstep_q;
  logic [CNT_W-1:0]   vcount_q;
  logic [CNT_W-1:0]   n_used;
  logic [ADDR_W-1:0]  seg_q;
  logic [DIV_CNT_W-1:0] divcnt_q;
  logic               m_valid_q;
  logic               m_user_q;
  logic [ROOT_W-1:0]  m_dist_q;
  logic [ROOT_W-1:0]  dist_q;

  logic signed [COORD_W-1:0] px_q, py_q, ax_q, ay_q, bx_q, by_q;
  logic signed [DIFF_W-1:0]  vx_q, vy_q, dx_q, dy_q, wx_q, wy_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [DD_W-1:0]           dd_q, dv_q, dw_q;
  logic signed [DOT_W-1:0]   vd_q, cr_q;
  logic [NUM_W-1:0]          num_q;
  logic [CAND_W-1:0]         rem_q, nsh_q, quo_q, best_q;

  logic              accept, out_free, idx_ok;
  logic [IDX_W-1:0]  in_idx;
  logic [COORD_W-1:0] in_x, in_y;
  logic signed [MUL_W-1:0] op_a, op_b;
  logic [DOT_W-1:0]  cr_abs;
  logic [MAG_W-1:0]  mag;
  logic              dd_zero, vd_pos, vd_ge, use_div;
  logic [CAND_W-1:0] cand_direct, cand, best_new, quo_next;
  logic [CAND_W:0]   rem_s;
  logic              div_fit;
  logic              seg_done, more_seg, sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_x   = s_axis_tdata[IDX_W +: COORD_W];
  assign in_y   = s_axis_tdata[IDX_W+COORD_W +: COORD_W];

  assign n_used = (vcount_q < VCOUNT_MIN) ? VCOUNT_MIN :
                  (vcount_q > VCOUNT_MAX) ? VCOUNT_MAX : vcount_q;
  assign idx_ok = CNT_W'(in_idx) < n_used;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // segment arithmetic
  assign cr_abs = cr_q[DOT_W-1] ? DOT_W'(-cr_q) : DOT_W'(cr_q);
  assign mag    = cr_abs[MAG_W-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (mstep_q)
      MS_DXDX: begin op_a = MUL_W'(dx_q); op_b = MUL_W'(dx_q); end
      MS_DYDY: begin op_a = MUL_W'(dy_q); op_b = MUL_W'(dy_q); end
      MS_VXDX: begin op_a = MUL_W'(vx_q); op_b = MUL_W'(dx_q); end
      MS_VYDY: begin op_a = MUL_W'(vy_q); op_b = MUL_W'(dy_q); end
      MS_VXVX: begin op_a = MUL_W'(vx_q); op_b = MUL_W'(vx_q); end
      MS_VYVY: begin op_a = MUL_W'(vy_q); op_b = MUL_W'(vy_q); end
      MS_WXWX: begin op_a = MUL_W'(wx_q); op_b = MUL_W'(wx_q); end
      MS_WYWY: begin op_a = MUL_W'(wy_q); op_b = MUL_W'(wy_q); end
      MS_VXDY: begin op_a = MUL_W'(vx_q); op_b = MUL_W'(dy_q); end
      MS_VYDX: begin op_a = MUL_W'(vy_q); op_b = MUL_W'(dx_q); end
      MS_HH: begin
        op_a = $signed(MUL_W'(mag[MAG_W-1:MAG_LO_W]));
        op_b = $signed(MUL_W'(mag[MAG_W-1:MAG_LO_W]));
      end
      MS_HL: begin
        op_a = $signed(MUL_W'(mag[MAG_W-1:MAG_LO_W]));
        op_b = $signed(MUL_W'(mag[MAG_LO_W-1:0]));
      end
      MS_LL: begin
        op_a = $signed(MUL_W'(mag[MAG_LO_W-1:0]));
        op_b = $signed(MUL_W'(mag[MAG_LO_W-1:0]));
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign dd_zero     = dd_q == '0;
  assign vd_pos      = !vd_q[DOT_W-1] && (vd_q != '0);
  assign vd_ge       = vd_q >= $signed({1'b0, dd_q});
  assign use_div     = !dd_zero && vd_pos && !vd_ge;
  assign cand_direct = (dd_zero || !vd_pos) ? dv_q[CAND_W-1:0] : dw_q[CAND_W-1:0];

  assign rem_s    = {rem_q, nsh_q[CAND_W-1]};
  assign div_fit  = (CAND_W+1)'(rem_s) >= (CAND_W+1)'(dd_q);
  assign quo_next = {quo_q[CAND_W-2:0], div_fit};

  assign seg_done = ((state_q == ST_MUL) && (mstep_q == MS_DECIDE) && !use_div) ||
                    ((state_q == ST_DIV) && (divcnt_q == DIV_CNT_W'(CAND_W - 1)));
  assign cand     = (state_q == ST_DIV) ? quo_next : cand_direct;
  assign best_new = ((seg_q == '0) || (cand < best_q)) ? cand : best_q;
  assign more_seg = ((CNT_W+1)'(seg_q) + (CNT_W+1)'(2)) < (CNT_W+1)'(n_used);

  always_comb begin
    state_d    = state_q;
    rd_addr    = '0;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == KIND_QUERY)) begin
          state_d = ST_RDA;
        end
      end
      ST_RDA: begin
        state_d = ST_RDB;
      end
      ST_RDB: begin
        rd_addr = ADDR_W'(1);
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        state_d = ST_MUL;
      end
      ST_MUL, ST_DIV: begin
        if ((state_q == ST_MUL) && (mstep_q == MS_DECIDE) && use_div) begin
          state_d = ST_DIV;
        end else if (seg_done) begin
          if (more_seg) begin
            rd_addr = ADDR_W'(seg_q + ADDR_W'(2));
            state_d = ST_DIFF;
          end else begin
            sqrt_start = 1'b1;
            state_d    = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // vertex memories
  always_ff @(posedge clk_i) begin
    if (accept && (s_axis_tuser == KIND_LOAD) && idx_ok) begin
      mem_x[in_idx[ADDR_W-1:0]] <= in_x;
      mem_y[in_idx[ADDR_W-1:0]] <= in_y;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcount_q  <= VCOUNT_RESET;
      mstep_q   <= MS_DXDX;
      seg_q     <= '0;
      divcnt_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (state_q == ST_DIFF) begin
        mstep_q <= MS_DXDX;
      end else if ((state_q == ST_MUL) && (mstep_q != MS_DECIDE)) begin
        mstep_q <= mul_step_e'(mstep_q + 4'd1);
      end
      if (state_q == ST_RDA) begin
        seg_q <= '0;
      end else if (seg_done && more_seg) begin
        seg_q <= seg_q + ADDR_W'(1);
      end
      if (state_q == ST_DIV) begin
        divcnt_q <= divcnt_q + DIV_CNT_W'(1);
      end else begin
        divcnt_q <= '0;
      end
      if (accept && (s_axis_tuser == KIND_LOAD)) begin
        m_valid_q <= 1'b1;
      end else if ((state_q == ST_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= in_x;
      py_q <= in_y;
    end
    if (state_q == ST_RDB) begin
      ax_q <= rdx_q;
      ay_q <= rdy_q;
    end
    if (state_q == ST_DIFF) begin
      bx_q <= rdx_q;
      by_q <= rdy_q;
      vx_q <= DIFF_W'(px_q) - DIFF_W'(ax_q);
      vy_q <= DIFF_W'(py_q) - DIFF_W'(ay_q);
      dx_q <= DIFF_W'($signed(rdx_q)) - DIFF_W'(ax_q);
      dy_q <= DIFF_W'($signed(rdy_q)) - DIFF_W'(ay_q);
      wx_q <= DIFF_W'(px_q) - DIFF_W'($signed(rdx_q));
      wy_q <= DIFF_W'(py_q) - DIFF_W'($signed(rdy_q));
    end
    prod_q <= op_a * op_b;
    // accumulate the product issued one step earlier
    if (state_q == ST_MUL) begin
      case (mstep_q)
        MS_DYDY:   dd_q  <= prod_q[DD_W-1:0];
        MS_VXDX:   dd_q  <= dd_q + prod_q[DD_W-1:0];
        MS_VYDY:   vd_q  <= prod_q[DOT_W-1:0];
        MS_VXVX:   vd_q  <= vd_q + prod_q[DOT_W-1:0];
        MS_VYVY:   dv_q  <= prod_q[DD_W-1:0];
        MS_WXWX:   dv_q  <= dv_q + prod_q[DD_W-1:0];
        MS_WYWY:   dw_q  <= prod_q[DD_W-1:0];
        MS_VXDY:   dw_q  <= dw_q + prod_q[DD_W-1:0];
        MS_VYDX:   cr_q  <= prod_q[DOT_W-1:0];
        MS_GAP:    cr_q  <= cr_q - prod_q[DOT_W-1:0];
        MS_HL:     num_q <= {prod_q[2*MAG_HI_W-1:0], (2*MAG_LO_W)'(0)};
        MS_LL:     num_q <= num_q + (NUM_W'(prod_q[MAG_W-1:0]) << (MAG_LO_W + 1));
        MS_TAIL:   num_q <= num_q + NUM_W'(prod_q[2*MAG_LO_W-1:0]);
        MS_DECIDE: begin
          rem_q <= num_q[NUM_W-1:CAND_W];
          nsh_q <= num_q[CAND_W-1:0];
          quo_q <= '0;
        end
        default: ;
      endcase
    end
    if (state_q == ST_DIV) begin
      rem_q <= div_fit ? CAND_W'(rem_s - (CAND_W+1)'(dd_q)) : CAND_W'(rem_s);
      nsh_q <= {nsh_q[CAND_W-2:0], 1'b0};
      quo_q <= quo_next;
    end
    if (seg_done) begin
      best_q <= best_new;
      if (more_seg) begin
        ax_q <= bx_q;
        ay_q <= by_q;
      end
    end
    if ((state_q == ST_SQRT) && sqrt_done) begin
      dist_q <= sqrt_root;
    end
    if (accept && (s_axis_tuser == KIND_LOAD)) begin
      m_user_q <= idx_ok ? STATUS_OK : STATUS_RANGE;
      m_dist_q <= '0;
    end else if ((state_q == ST_OUT) && out_free) begin
      m_user_q <= STATUS_OK;
      m_dist_q <= dist_q;
    end
  end

  ppd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (best_new),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_dist_q);

endmodule

`default_nettype wire

[hdl/ppd_checker.sv]
// Port-level checks of the point to polyline distance block, bound to the top.
// Depends on ppd_pkg and point_to_polyline_distance_top.
`timescale 1ns / 1ps
`default_nettype none

module ppd_checker import ppd_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser,
  input wire logic                  cfg_we_i,
  input wire logic [CNT_W-1:0]      cfg_wdata_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tready)
    else $error("input ready while output register is blocked");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD) |=> m_axis_tvalid)
    else $error("load item gave no result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
    else $error("input taken during a query");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_RANGE) |-> (m_axis_tdata == '0))
    else $error("range error carries a distance");

endmodule

bind point_to_polyline_distance_top ppd_checker u_ppd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i)
);

`default_nettype wire
